>>> hw/rtl/go_to_goal_p_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Go-to-goal controller assertion macros
// Shared concurrent assertion forms for the controller checkers.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_P_CONTROLLER_UNIT_DEFINES_SVH
`define GO_TO_GOAL_P_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gtg assertion failed");

// Next-cycle implication, disabled while in reset
`define GTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gtg assertion failed");

`endif

>>> hw/rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Widths, register codes, sequencer states and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

  // Field widths
  localparam int PosW  = 24;
  localparam int YawW  = 15;
  localparam int GainW = 16;
  localparam int LimW  = 19;
  localparam int TolW  = 16;
  localparam int LinW  = 19;
  localparam int AngW  = 20;

  // Datapath widths
  localparam int DiffW = PosW + 1;        // goal - pose
  localparam int MulW  = DiffW + 1;       // signed multiplier operand
  localparam int ProdW = 2 * MulW;
  localparam int RootW = DiffW;           // floor sqrt of dx^2 + dy^2
  localparam int SqW   = 2 * RootW;       // radicand
  localparam int SqrtIters  = RootW;
  localparam int SqrtTopBit = 2 * (RootW - 1);
  localparam int SqrtCntW   = $clog2(SqrtIters);

  // CORDIC
  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  localparam int CordicIters = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int StepW       = $clog2(TableLen);
  localparam int AngFrac     = 20;
  localparam int VecW        = DiffW + AngFrac + 3;
  localparam int ZW          = 24;
  localparam int HeadW       = ZW - 8;
  localparam int ErrW        = HeadW + 1;
  localparam logic signed [ZW-1:0] HalfPiZ = ZW'(1647099);
  localparam logic signed [ZW-1:0] ZRound  = ZW'(128);

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = PosW;

  typedef enum logic [CfgIdxW-1:0] {
    RegGoalX       = 3'd0,
    RegGoalY       = 3'd1,
    RegLinGain     = 3'd2,
    RegAngGain     = 3'd3,
    RegLinLimit    = 3'd4,
    RegAngLimit    = 3'd5,
    RegArriveTol   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StSqX,
    StSqY,
    StRootStart,
    StRoot,
    StLin,
    StAng,
    StFin
  } state_e;

  // atan(2^-i) in units of 2^-20 rad
  function automatic logic signed [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(823550);
      5'd1:    v = ZW'(486170);
      5'd2:    v = ZW'(256879);
      5'd3:    v = ZW'(130396);
      5'd4:    v = ZW'(65451);
      5'd5:    v = ZW'(32757);
      5'd6:    v = ZW'(16383);
      5'd7:    v = ZW'(8192);
      5'd8:    v = ZW'(4096);
      5'd9:    v = ZW'(2048);
      5'd10:   v = ZW'(1024);
      5'd11:   v = ZW'(512);
      5'd12:   v = ZW'(256);
      5'd13:   v = ZW'(128);
      5'd14:   v = ZW'(64);
      5'd15:   v = ZW'(32);
      5'd16:   v = ZW'(16);
      5'd17:   v = ZW'(8);
      5'd18:   v = ZW'(4);
      5'd19:   v = ZW'(2);
      5'd20:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gtg_mul.sv
// ----------------------------------------------------------------------------
// gtg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_mul (
  input  wire logic                              clk_i,
  input  wire logic signed [gtg_pkg::MulW-1:0]   a_i,
  input  wire logic signed [gtg_pkg::MulW-1:0]   b_i,
  output logic signed      [gtg_pkg::ProdW-1:0]  prod_o
);
  import gtg_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  // Product register, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> hw/rtl/gtg_sqrt.sv
// ----------------------------------------------------------------------------
// gtg_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [gtg_pkg::SqW-1:0]       radicand_i,
  output logic                               busy_o,
  output logic      [gtg_pkg::RootW-1:0]     root_o
);
  import gtg_pkg::*;

  logic [SqW-1:0]      rem_q, rem_d;
  logic [SqW-1:0]      root_q, root_d;
  logic [SqW-1:0]      bit_q, bit_d;
  logic [SqrtCntW-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [SqW:0]        trial;

  // One restoring step per cycle
  always_comb begin
    trial  = {1'b0, root_q} + {1'b0, bit_q};
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = radicand_i;
      root_d = '0;
      bit_d  = SqW'(1) << SqrtTopBit;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d  = rem_q - trial[SqW-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + SqrtCntW'(1);
      if (cnt_q == SqrtCntW'(SqrtIters - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q[RootW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic
// Iterative CORDIC vectoring unit giving atan2(dy, dx) in Q4.12.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_cordic (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [gtg_pkg::DiffW-1:0]  dx_i,
  input  wire logic signed [gtg_pkg::DiffW-1:0]  dy_i,
  output logic                                   busy_o,
  output logic signed      [gtg_pkg::HeadW-1:0]  heading_o
);
  import gtg_pkg::*;

  localparam int PadW = VecW - DiffW - AngFrac;

  logic signed [VecW-1:0] x_q, x_d, y_q, y_d;
  logic signed [VecW-1:0] xs, ys, xsh, ysh;
  logic signed [ZW-1:0]   z_q, z_d, z_rnd, step_ang;
  logic [StepW-1:0]       iter_q, iter_d;
  logic                   busy_q, busy_d;

  // Scaled start vector and one micro-rotation per cycle
  always_comb begin
    xs       = {{PadW{dx_i[DiffW-1]}}, dx_i, {AngFrac{1'b0}}};
    ys       = {{PadW{dy_i[DiffW-1]}}, dy_i, {AngFrac{1'b0}}};
    xsh      = x_q >>> iter_q;
    ysh      = y_q >>> iter_q;
    step_ang = atan_entry(iter_q);
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    iter_d   = iter_q;
    busy_d   = busy_q;
    if (start_i) begin
      iter_d = '0;
      busy_d = 1'b1;
      if (xs[VecW-1]) begin
        // left half plane: pre-rotate by a quarter turn
        if (!ys[VecW-1]) begin
          x_d = ys;
          y_d = -xs;
          z_d = HalfPiZ;
        end else begin
          x_d = -ys;
          y_d = xs;
          z_d = -HalfPiZ;
        end
      end else begin
        x_d = xs;
        y_d = ys;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (!y_q[VecW-1]) begin
        x_d = x_q + ysh;
        y_d = y_q - xsh;
        z_d = z_q + step_ang;
      end else begin
        x_d = x_q - ysh;
        y_d = y_q + xsh;
        z_d = z_q - step_ang;
      end
      iter_d = iter_q + StepW'(1);
      if (iter_q == StepW'(CordicIters - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  // Vector and angle registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // Round half up from 2^-20 to 2^-12 rad
  assign z_rnd     = z_q + ZRound;
  assign heading_o = z_rnd[ZW-1:8];
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

>>> hw/rtl/go_to_goal_p_controller_unit.sv
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_unit
// Proportional go-to-goal controller: distance and heading to a goal,
// gain, saturation and a sticky arrival flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o | pose_x_i, pose_y_i, pose_yaw_i
//  out     | output    | out_valid_o/out_stall_i | linear_cmd_o, angular_cmd_o,
//          |           |                       | still_moving_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  From accept to result an item goes through the squares on the shared
//  multiplier, the bit-serial square root (the CORDIC runs beside it in 16
//  steps), then the gain products and saturation.
//  The next item is accepted the cycle after the result is registered.
//  A stalled result holds in the output register; the next item is then
//  worked through and waits in its last step. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_p_controller_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // pose items
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [gtg_pkg::PosW-1:0]       pose_x_i,
  input  wire logic signed [gtg_pkg::PosW-1:0]       pose_y_i,
  input  wire logic signed [gtg_pkg::YawW-1:0]       pose_yaw_i,
  // command items
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic             [gtg_pkg::LinW-1:0]       linear_cmd_o,
  output logic signed      [gtg_pkg::AngW-1:0]       angular_cmd_o,
  output logic                                       still_moving_o,
  // configuration writes
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic        [gtg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic        [gtg_pkg::CfgDataW-1:0]   cfg_data_i
);
  import gtg_pkg::*;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [PosW-1:0] goal_x_q, goal_y_q;
  logic [GainW-1:0]       lin_gain_q, ang_gain_q;
  logic [LimW-1:0]        lin_limit_q, ang_limit_q;
  logic [TolW-1:0]        tol_q;

  // Item datapath
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic signed [YawW-1:0]  yaw_q;
  logic [SqW-1:0]          sqx_q;
  logic [LinW-1:0]         lin_q;
  logic                    arrived_q;

  // Output register
  logic                    out_valid_q;
  logic [LinW-1:0]         lin_out_q;
  logic signed [AngW-1:0]  ang_out_q;
  logic                    moving_q;

  // Sequencer outputs
  logic                    accept;
  logic                    out_write;
  logic                    unit_start;
  logic signed [MulW-1:0]  mul_a, mul_b;

  // Unit results
  logic signed [ProdW-1:0] prod;
  logic [RootW-1:0]        goal_dist;
  logic                    sqrt_busy, cordic_busy;
  logic signed [HeadW-1:0] heading;

  // Derived values
  logic signed [DiffW-1:0] dx_in, dy_in;
  logic signed [ErrW-1:0]  err;
  logic [SqW-1:0]          radicand;
  logic [ProdW-1:0]        lin_sum;
  logic [ProdW-9:0]        lin_sh;
  logic signed [ProdW-1:0] ang_sum, ang_sh, ang_lim;
  logic signed [AngW-1:0]  ang_sat;
  logic                    near;

  gtg_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  gtg_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .radicand_i (radicand),
    .busy_o     (sqrt_busy),
    .root_o     (goal_dist)
  );

  gtg_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (unit_start),
    .dx_i      (dx_q),
    .dy_i      (dy_q),
    .busy_o    (cordic_busy),
    .heading_o (heading)
  );

  // Offsets and heading error
  assign dx_in    = $signed({goal_x_q[PosW-1], goal_x_q}) - $signed({pose_x_i[PosW-1], pose_x_i});
  assign dy_in    = $signed({goal_y_q[PosW-1], goal_y_q}) - $signed({pose_y_i[PosW-1], pose_y_i});
  assign err      = $signed({heading[HeadW-1], heading})
                  - $signed({{(ErrW-YawW){yaw_q[YawW-1]}}, yaw_q});
  assign radicand = sqx_q + prod[SqW-1:0];
  assign near     = ({{(RootW-TolW){1'b0}}, tol_q} >= goal_dist);

  // Linear command: round, then cap
  always_comb begin
    lin_sum = prod + ProdW'(128);
    lin_sh  = lin_sum[ProdW-1:8];
  end

  // Angular command: round, then clamp to +-limit
  always_comb begin
    ang_sum = prod + ProdW'(128);
    ang_sh  = ang_sum >>> 8;
    ang_lim = $signed({{(ProdW-LimW){1'b0}}, ang_limit_q});
    if (ang_sh > ang_lim) begin
      ang_sat = ang_lim[AngW-1:0];
    end else if (ang_sh < -ang_lim) begin
      ang_sat = AngW'(-ang_lim);
    end else begin
      ang_sat = ang_sh[AngW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:      if (in_valid_i) state_d = StSqX;
      StSqX:       state_d = StSqY;
      StSqY:       state_d = StRootStart;
      StRootStart: state_d = StRoot;
      StRoot:      if (!sqrt_busy && !cordic_busy) state_d = StLin;
      StLin:       state_d = StAng;
      StAng:       state_d = StFin;
      StFin:       if (!out_valid_q || !out_stall_i) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    accept     = 1'b0;
    out_write  = 1'b0;
    unit_start = 1'b0;
    mul_a      = $signed({{(MulW-GainW){1'b0}}, ang_gain_q});
    mul_b      = $signed({{(MulW-ErrW){err[ErrW-1]}}, err});
    case (state_q)
      StIdle:      accept = in_valid_i;
      StSqX: begin
        mul_a = $signed({dx_q[DiffW-1], dx_q});
        mul_b = $signed({dx_q[DiffW-1], dx_q});
      end
      StSqY: begin
        mul_a = $signed({dy_q[DiffW-1], dy_q});
        mul_b = $signed({dy_q[DiffW-1], dy_q});
      end
      StRootStart: unit_start = 1'b1;
      StLin: begin
        mul_a = $signed({{(MulW-GainW){1'b0}}, lin_gain_q});
        mul_b = $signed({{(MulW-RootW){1'b0}}, goal_dist});
      end
      StFin:       out_write = !out_valid_q || !out_stall_i;
      default:     ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      arrived_q   <= 1'b0;
      goal_x_q    <= PosW'(4096);
      goal_y_q    <= PosW'(4096);
      lin_gain_q  <= GainW'(384);
      ang_gain_q  <= GainW'(1536);
      lin_limit_q <= LimW'(524287);
      ang_limit_q <= LimW'(524287);
      tol_q       <= TolW'(41);
    end else begin
      state_q <= state_d;
      if (out_write) begin
        out_valid_q <= 1'b1;
        if (near) arrived_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegGoalX:     goal_x_q    <= cfg_data_i[PosW-1:0];
          RegGoalY:     goal_y_q    <= cfg_data_i[PosW-1:0];
          RegLinGain:   lin_gain_q  <= cfg_data_i[GainW-1:0];
          RegAngGain:   ang_gain_q  <= cfg_data_i[GainW-1:0];
          RegLinLimit:  lin_limit_q <= cfg_data_i[LimW-1:0];
          RegAngLimit:  ang_limit_q <= cfg_data_i[LimW-1:0];
          RegArriveTol: tol_q       <= cfg_data_i[TolW-1:0];
          default:      ;
        endcase
      end
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q  <= dx_in;
      dy_q  <= dy_in;
      yaw_q <= pose_yaw_i;
    end
    if (state_q == StSqY) begin
      sqx_q <= prod[SqW-1:0];
    end
    if (state_q == StAng) begin
      if (lin_sh > (ProdW-8)'(lin_limit_q)) begin
        lin_q <= lin_limit_q;
      end else begin
        lin_q <= lin_sh[LinW-1:0];
      end
    end
    if (out_write) begin
      lin_out_q <= near ? '0 : lin_q;
      ang_out_q <= near ? '0 : ang_sat;
      moving_q  <= !(arrived_q || near);
    end
  end

  assign in_stall_o     = (state_q != StIdle);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign linear_cmd_o   = lin_out_q;
  assign angular_cmd_o  = ang_out_q;
  assign still_moving_o = moving_q;

endmodule

`default_nettype wire

>>> hw/rtl/gtg_checker.sv
// ----------------------------------------------------------------------------
// gtg_checker
// Port-level checks on the go-to-goal controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "go_to_goal_p_controller_unit_defines.svh"

module gtg_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_stall_o,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire logic        [gtg_pkg::LinW-1:0]   linear_cmd_o,
  input  wire logic signed [gtg_pkg::AngW-1:0]   angular_cmd_o,
  input  wire logic                              still_moving_o
);

  logic seen_arrival_q;

  // Remember that an arrived result has been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_arrival_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && !still_moving_o) begin
      seen_arrival_q <= 1'b1;
    end
  end

  // A stalled result holds
  `GTG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(linear_cmd_o) && $stable(angular_cmd_o) && $stable(still_moving_o))

  // Busy right after taking an item
  `GTG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Arrival is sticky across later results
  `GTG_ASSERT_NOW(a_arrival_sticky, out_valid_o && seen_arrival_q, !still_moving_o)

  // Symmetric clamp never reaches the most negative code
  `GTG_ASSERT_NOW(a_ang_symmetric, out_valid_o, angular_cmd_o != 20'sh80000)

endmodule

bind go_to_goal_p_controller_unit gtg_checker u_gtg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .linear_cmd_o   (linear_cmd_o),
  .angular_cmd_o  (angular_cmd_o),
  .still_moving_o (still_moving_o)
);

`default_nettype wire
